>>> hdl/imu_pkg.sv
package imu_pkg;

  localparam int DataW = 32;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_TRANS = 3'd3;
  localparam logic [2:0] OP_DET   = 3'd4;

  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_ROWS_A    = 2'd1;
  localparam logic [1:0] REG_COLS_A    = 2'd2;
  localparam logic [1:0] REG_COLS_B    = 2'd3;

  localparam logic [2:0] OP_RESET  = OP_MUL;
  localparam logic [3:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_ERROR
  } state_t;

  typedef enum logic [2:0] {
    FN_ADD,
    FN_SUB,
    FN_MUL,
    FN_PASS,
    FN_DFIRST,
    FN_DMID,
    FN_DLAST
  } fn_t;

  typedef struct packed {
    logic       wr_a;
    logic       wr_b;
    logic       rd;
    logic [2:0] a_row;
    logic [2:0] a_col;
    logic [2:0] b_row;
    logic [2:0] b_col;
    fn_t        fn;
    logic       acc_first;
    logic       acc_last;
    logic       neg;
    logic       emit;
    logic [2:0] emit_row;
    logic [2:0] emit_col;
    logic       emit_last;
    logic       emit_err;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic out_free;
  } dp_stat_t;

  // column picked from row f in term t of the Leibniz expansion
  function automatic logic [2:0] det_col(input logic three, input logic [2:0] t,
                                         input logic [1:0] f);
    logic [8:0] p;
    if (!three) begin
      return {2'b00, t[0] ^ f[0]};
    end
    case (t)
      3'd0:    p = {3'd2, 3'd1, 3'd0};
      3'd1:    p = {3'd1, 3'd2, 3'd0};
      3'd2:    p = {3'd2, 3'd0, 3'd1};
      3'd3:    p = {3'd0, 3'd2, 3'd1};
      3'd4:    p = {3'd1, 3'd0, 3'd2};
      3'd5:    p = {3'd0, 3'd1, 3'd2};
      default: p = {3'd2, 3'd1, 3'd0};
    endcase
    return p[3*f +: 3];
  endfunction

  function automatic logic det_neg(input logic three, input logic [2:0] t);
    logic n;
    if (three) begin
      case (t)
        3'd1, 3'd2, 3'd5: n = 1'b1;
        default:          n = 1'b0;
      endcase
    end else begin
      n = (t == 3'd1);
    end
    return n;
  endfunction

endpackage

>>> hdl/imu_in_if.sv
interface imu_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic        [2:0]  row;
  logic        [2:0]  col;
  logic signed [31:0] value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink (input valid, action, row, col, value, output ready);
endinterface

>>> hdl/imu_out_if.sv
interface imu_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  out_row;
  logic        [2:0]  out_col;
  logic signed [31:0] result;
  logic               last;
  logic               error;

  modport source (output valid, out_row, out_col, result, last, error, input ready);
  modport sink (input valid, out_row, out_col, result, last, error, output ready);
endinterface

>>> hdl/imu_ctrl.sv
module imu_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic              in_valid,
  input  logic [1:0]        action,
  output logic              in_ready,
  output imu_pkg::dp_cmd_t  dcmd,
  input  imu_pkg::dp_stat_t stat
);
  import imu_pkg::*;

  localparam logic [3:0] DimCap = 4'(MAX_DIM < 8 ? MAX_DIM : 8);

  state_t     state, state_next;
  logic [2:0] operation;
  logic [3:0] rows_a, cols_a, cols_b;
  logic [2:0] i, j, k;

  logic [3:0] ra, ca, cb, nr, nc;
  logic [2:0] nr_m1, nc_m1, kend, iend;
  logic       is_det, det3, det_ok, start, k_done, last_elem;

  function automatic logic [3:0] clamp(input logic [3:0] d);
    if (d == 4'd0) return 4'd1;
    if (d > DimCap) return DimCap;
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_RESET;
      rows_a    <= DIM_RESET;
      cols_a    <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OPERATION: operation <= cfg_data[2:0];
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_COLS_A:    cols_a    <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign ra     = clamp(rows_a);
  assign ca     = clamp(cols_a);
  assign cb     = clamp(cols_b);
  assign is_det = (operation == OP_DET);
  assign det3   = (rows_a == 4'd3) && (cols_a == 4'd3);
  assign det_ok = det3 || ((rows_a == 4'd2) && (cols_a == 4'd2));
  assign nr     = (operation == OP_TRANS) ? ca : ra;
  assign nc     = (operation == OP_MUL) ? cb : ((operation == OP_TRANS) ? ra : ca);
  assign nr_m1  = 3'(nr - 4'd1);
  assign nc_m1  = 3'(nc - 4'd1);
  assign kend   = is_det ? (det3 ? 3'd2 : 3'd1) : ((operation == OP_MUL) ? 3'(ca - 4'd1) : 3'd0);
  assign iend   = det3 ? 3'd5 : 3'd1;
  assign start  = (state == ST_IDLE) && in_valid && (action == ACT_START);
  assign k_done = (k == kend);
  assign last_elem = is_det || ((i == nr_m1) && (j == nc_m1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation < OP_DET) state_next = ST_ISSUE;
          else if (is_det) state_next = det_ok ? ST_ISSUE : ST_ERROR;
        end
      end
      ST_ISSUE: begin
        if (k_done && (!is_det || (i == iend))) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.sum_done && stat.out_free) state_next = last_elem ? ST_IDLE : ST_ISSUE;
      end
      ST_ERROR: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dcmd     = '0;
    dcmd.fn  = FN_ADD;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        dcmd.wr_a = in_valid && (action == ACT_LOAD_A);
        dcmd.wr_b = in_valid && (action == ACT_LOAD_B);
      end
      ST_ISSUE: begin
        dcmd.rd = 1'b1;
        if (is_det) begin
          dcmd.a_row     = k;
          dcmd.a_col     = det_col(det3, i, k[1:0]);
          dcmd.fn        = (k == 3'd0) ? FN_DFIRST : (k_done ? FN_DLAST : FN_DMID);
          dcmd.acc_first = (i == 3'd0);
          dcmd.acc_last  = k_done && (i == iend);
          dcmd.neg       = det_neg(det3, i);
        end else begin
          dcmd.acc_first = (k == 3'd0);
          dcmd.acc_last  = k_done;
          unique case (operation)
            OP_MUL: begin
              dcmd.fn    = FN_MUL;
              dcmd.a_row = i;
              dcmd.a_col = k;
              dcmd.b_row = k;
              dcmd.b_col = j;
            end
            OP_TRANS: begin
              dcmd.fn    = FN_PASS;
              dcmd.a_row = j;
              dcmd.a_col = i;
            end
            default: begin
              dcmd.fn    = (operation == OP_SUB) ? FN_SUB : FN_ADD;
              dcmd.a_row = i;
              dcmd.a_col = j;
              dcmd.b_row = i;
              dcmd.b_col = j;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        dcmd.emit      = stat.sum_done && stat.out_free;
        dcmd.emit_row  = is_det ? 3'd0 : i;
        dcmd.emit_col  = is_det ? 3'd0 : j;
        dcmd.emit_last = last_elem;
      end
      ST_ERROR: begin
        dcmd.emit      = stat.out_free;
        dcmd.emit_last = 1'b1;
        dcmd.emit_err  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (start) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (state == ST_ISSUE) begin
      if (k_done) begin
        k <= '0;
        if (is_det && (i != iend)) i <= i + 3'd1;
      end else begin
        k <= k + 3'd1;
      end
    end else if ((state == ST_DRAIN) && dcmd.emit && !last_elem) begin
      if (j == nc_m1) begin
        j <= '0;
        i <= i + 3'd1;
      end else begin
        j <= j + 3'd1;
      end
    end
  end

endmodule

>>> hdl/imu_datapath.sv
module imu_datapath #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  imu_pkg::dp_cmd_t  dcmd,
  output imu_pkg::dp_stat_t stat,
  input  logic [2:0]        wr_row,
  input  logic [2:0]        wr_col,
  input  logic [31:0]       wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_row,
  output logic [2:0]        out_col,
  output logic [31:0]       out_result,
  output logic              out_last,
  output logic              out_error
);
  import imu_pkg::*;

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(Depth);
  localparam int FW    = AW + 1;

  logic [DataW-1:0] mem_a [Depth];
  logic [DataW-1:0] mem_b [Depth];

  logic [DataW-1:0] rd_a, rd_b, h, p2, acc, mul_b, prod;
  logic             wr_ok;
  logic             s1_valid, s1_first, s1_last, s1_neg;
  fn_t              s1_fn;
  logic             s2_valid, s2_first, s2_last, s2_neg;
  logic             sum_done;

  function automatic logic [AW-1:0] addr_of(input logic [2:0] r, input logic [2:0] c);
    logic [FW-1:0] full;
    full = FW'(r) * FW'(MAX_DIM) + FW'(c);
    if (full >= FW'(Depth)) full = full - FW'(Depth);
    return full[AW-1:0];
  endfunction

  assign wr_ok = (int'(wr_row) < MAX_DIM) && (int'(wr_col) < MAX_DIM);

  always_ff @(posedge clk) begin
    if (dcmd.wr_a && wr_ok) mem_a[addr_of(wr_row, wr_col)] <= wr_data;
    rd_a <= mem_a[addr_of(dcmd.a_row, dcmd.a_col)];
  end

  always_ff @(posedge clk) begin
    if (dcmd.wr_b && wr_ok) mem_b[addr_of(wr_row, wr_col)] <= wr_data;
    rd_b <= mem_b[addr_of(dcmd.b_row, dcmd.b_col)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= dcmd.rd;
    end
    s1_fn    <= dcmd.fn;
    s1_first <= dcmd.acc_first;
    s1_last  <= dcmd.acc_last;
    s1_neg   <= dcmd.neg;
  end

  assign mul_b = (s1_fn == FN_MUL) ? rd_b : h;
  assign prod  = rd_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_fn != FN_DFIRST) && (s1_fn != FN_DMID);
    end
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_neg   <= s1_neg;
    if (s1_valid) begin
      case (s1_fn)
        FN_ADD:    p2 <= rd_a + rd_b;
        FN_SUB:    p2 <= rd_a - rd_b;
        FN_MUL:    p2 <= prod;
        FN_PASS:   p2 <= rd_a;
        FN_DFIRST: h  <= rd_a;
        FN_DMID:   h  <= prod;
        FN_DLAST:  p2 <= prod;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) acc <= (s2_first ? '0 : acc) + (s2_neg ? -p2 : p2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_done <= 1'b0;
    end else if (s2_valid && s2_last) begin
      sum_done <= 1'b1;
    end else if (dcmd.emit) begin
      sum_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (dcmd.emit) begin
      out_row    <= dcmd.emit_row;
      out_col    <= dcmd.emit_col;
      out_result <= dcmd.emit_err ? '0 : acc;
      out_last   <= dcmd.emit_last;
      out_error  <= dcmd.emit_err;
    end
  end

  assign stat.sum_done = sum_done;
  assign stat.out_free = !out_valid || out_ready;

endmodule

>>> hdl/integer_matrix_unit.sv
// Channel  Role    Carries
// cmd      in      action, row, col, value (load A, load B, start)
// res      out     out_row, out_col, result, last, error
// cfg_*    write   operation, rows_a, cols_a, cols_b
//
// A load request is written into its store as it is taken; requests are taken only between runs.
// Add, subtract, transpose: one store read per result element; each element is emitted before the next is issued.
// Multiply: cols_a products per element, one A and one B read port per cycle while issuing.
// Determinant: 4 (2x2) or 18 (3x3) reads of A through one shared multiplier,
// then the result is emitted once its sum is finished.
// Reset is synchronous; the stores are not cleared. A stalled result holds
// the engine until the output register frees.
module integer_matrix_unit #(
  parameter int MAX_DIM = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data,
  imu_in_if.sink     cmd,
  imu_out_if.source  res
);
  import imu_pkg::*;

  dp_cmd_t     dcmd;
  dp_stat_t    stat;
  logic        in_ready;
  logic [31:0] out_result;

  imu_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (cmd.valid),
    .action    (cmd.action),
    .in_ready  (in_ready),
    .dcmd      (dcmd),
    .stat      (stat)
  );

  imu_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dcmd       (dcmd),
    .stat       (stat),
    .wr_row     (cmd.row),
    .wr_col     (cmd.col),
    .wr_data    (cmd.value),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_row    (res.out_row),
    .out_col    (res.out_col),
    .out_result (out_result),
    .out_last   (res.last),
    .out_error  (res.error)
  );

  assign cmd.ready  = in_ready;
  assign res.result = out_result;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    dcmd.emit |-> stat.out_free)
    else $error("result emitted into a full output register");

  a_issue_clear: assert property (@(posedge clk) disable iff (rst)
    dcmd.rd |-> !stat.sum_done)
    else $error("read issued while a sum waits");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    dcmd.emit |-> (stat.sum_done || dcmd.emit_err))
    else $error("result emitted with no finished sum");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (dcmd.wr_a || dcmd.wr_b) |-> in_ready)
    else $error("store written outside idle");

endmodule
